// ----- rtl/tgwd_pkg.sv -----
// ----------------------------------------------------------------------------
// tgwd_pkg: shared types and constants of the tilt gesture window detector
// Word formats, operation and gesture codes, register indexes, window size.
// ----------------------------------------------------------------------------
package tgwd_pkg;

  // Samples held in the window, counting the one arriving now
  localparam int unsigned WINDOW_DEPTH = 8;
  // Stored cells: the newest sample is compared as it arrives
  localparam int unsigned CELL_COUNT = WINDOW_DEPTH - 1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [1:0] GEST_NONE = 2'd0;
  localparam logic [1:0] GEST_FALL = 2'd1;
  localparam logic [1:0] GEST_RISE = 2'd2;

  localparam logic CFG_Z_CHANGE_LIMIT     = 1'b0;
  localparam logic CFG_SAME_SAMPLE_MARGIN = 1'b1;

  localparam logic [15:0] Z_CHANGE_LIMIT_RST     = 16'd2000;
  localparam logic [15:0] SAME_SAMPLE_MARGIN_RST = 16'd100;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0] gesture_code;
    logic       sample_taken;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- rtl/tgwd_cell.sv -----
// ----------------------------------------------------------------------------
// tgwd_cell: one z cell of the window chain
// Holds one z value and its valid flag; takes its neighbor's on shift.
// ----------------------------------------------------------------------------
module tgwd_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  tgwd_pkg::cell_ctrl_t ctrl,
  input  logic signed [15:0]  z_in,
  input  logic                vld_in,
  output logic signed [15:0]  z_out,
  output logic                vld_out
);

  logic signed [15:0] z_r;
  logic               vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctrl.clear) begin
      vld_r <= 1'b0;
    end else if (ctrl.shift) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      z_r <= z_in;
    end
  end

  assign z_out   = z_r;
  assign vld_out = vld_r;

endmodule

// ----- rtl/tgwd_out_buf.sv -----
// ----------------------------------------------------------------------------
// tgwd_out_buf: output register with skid stage
// Keeps input acceptance going while a result word waits downstream.
// ----------------------------------------------------------------------------
module tgwd_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tgwd_pkg::out_word_t  push_word,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tgwd_pkg::out_word_t  out_word
);

  logic                out_valid_r;
  logic                skid_valid_r;
  tgwd_pkg::out_word_t out_word_r;
  tgwd_pkg::out_word_t skid_word_r;
  logic                out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      // drain the skid word first; no push can happen while it is held
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word_r <= skid_valid_r ? skid_word_r : push_word;
    end else if (push) begin
      skid_word_r <= push_word;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without an output word");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("word pushed while skid stage full");

endmodule

// ----- rtl/tilt_gesture_window_detector_top.sv -----
// ----------------------------------------------------------------------------
// tilt_gesture_window_detector_top: tilt gesture detector over a z window
// Drops near-duplicate samples, shifts z through a chain of cells and flags
// a rise or fall between the newest and oldest z of a full window.
// Result: registered in the output register, or the skid stage while stalled.
// Throughput: one word per cycle unless stalled; compares the arriving word.
// Backpressure: a two-word output buffer absorbs one stalled result.
// Reset (synchronous, rst_n low): window empty, last sample zero,
// registers back to limit 2000 and margin 100, no result pending.
// ----------------------------------------------------------------------------
module tilt_gesture_window_detector_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tgwd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output tgwd_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  logic [15:0]         z_change_limit_r;
  logic [15:0]         same_sample_margin_r;
  logic signed [15:0]  prev_x_r;
  logic signed [15:0]  prev_y_r;
  logic signed [15:0]  prev_z_r;

  logic                accept;
  logic                is_clear;
  logic                is_dup;
  logic                take;
  logic                buf_full;
  tgwd_pkg::cell_ctrl_t cell_ctrl;
  tgwd_pkg::out_word_t res_word;

  logic signed [15:0]  cell_z   [tgwd_pkg::CELL_COUNT];
  logic                cell_vld [tgwd_pkg::CELL_COUNT];
  logic signed [15:0]  oldest_z;
  logic                window_full;
  logic signed [16:0]  fall_diff;
  logic signed [16:0]  rise_diff;
  logic signed [16:0]  limit_ext;

  function automatic logic near(input logic signed [15:0] a,
                                input logic signed [15:0] b,
                                input logic [15:0] margin);
    logic signed [16:0] d;
    logic [16:0]        mag;
    d   = 17'(a) - 17'(b);
    mag = d[16] ? 17'(-d) : 17'(d);
    return mag < {1'b0, margin};
  endfunction

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_change_limit_r     <= tgwd_pkg::Z_CHANGE_LIMIT_RST;
      same_sample_margin_r <= tgwd_pkg::SAME_SAMPLE_MARGIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tgwd_pkg::CFG_Z_CHANGE_LIMIT:     z_change_limit_r     <= cfg_data;
        tgwd_pkg::CFG_SAME_SAMPLE_MARGIN: same_sample_margin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample filter
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;
  assign is_clear = (in_word.operation == tgwd_pkg::OP_CLEAR);
  assign is_dup   = near(in_word.accel_x, prev_x_r, same_sample_margin_r) &&
                    near(in_word.accel_y, prev_y_r, same_sample_margin_r) &&
                    near(in_word.accel_z, prev_z_r, same_sample_margin_r);
  assign take     = accept && !is_clear && !is_dup;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      prev_z_r <= '0;
    end else if (take) begin
      prev_x_r <= in_word.accel_x;
      prev_y_r <= in_word.accel_y;
      prev_z_r <= in_word.accel_z;
    end
  end

  // window chain: cell 0 holds the last taken z, the far end the oldest
  assign cell_ctrl.shift = take;
  assign cell_ctrl.clear = accept && is_clear;

  for (genvar i = 0; i < tgwd_pkg::CELL_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      tgwd_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cell_ctrl),
        .z_in    (in_word.accel_z),
        .vld_in  (1'b1),
        .z_out   (cell_z[i]),
        .vld_out (cell_vld[i])
      );
    end else begin : g_body
      tgwd_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cell_ctrl),
        .z_in    (cell_z[i-1]),
        .vld_in  (cell_vld[i-1]),
        .z_out   (cell_z[i]),
        .vld_out (cell_vld[i])
      );
    end
  end

  assign oldest_z    = cell_z[tgwd_pkg::CELL_COUNT-1];
  assign window_full = cell_vld[tgwd_pkg::CELL_COUNT-1];
  assign fall_diff   = 17'(oldest_z) - 17'(in_word.accel_z);
  assign rise_diff   = 17'(in_word.accel_z) - 17'(oldest_z);
  assign limit_ext   = $signed({1'b0, z_change_limit_r});

  always_comb begin
    res_word.sample_taken = take;
    res_word.gesture_code = tgwd_pkg::GEST_NONE;
    if (take && window_full) begin
      priority if (fall_diff > limit_ext) begin
        res_word.gesture_code = tgwd_pkg::GEST_FALL;
      end else if (rise_diff > limit_ext) begin
        res_word.gesture_code = tgwd_pkg::GEST_RISE;
      end else begin
        res_word.gesture_code = tgwd_pkg::GEST_NONE;
      end
    end
  end

  tgwd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_word (res_word),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cell_ctrl.clear |=> !cell_vld[0] && !window_full)
    else $error("window not empty after clear");

  a_gesture_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.gesture_code != tgwd_pkg::GEST_NONE) |->
      out_word.sample_taken)
    else $error("gesture reported for a dropped word");

  a_no_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.gesture_code != 2'd3))
    else $error("undefined gesture code");

  a_take_loads_prev: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (prev_z_r == $past(in_word.accel_z)) && (cell_z[0] == prev_z_r))
    else $error("last sample and window head disagree");

endmodule

// ----- bench/tilt_gesture_window_detector_top_test.sv -----
// ----------------------------------------------------------------------------
// tilt_gesture_window_detector_top_test: self-checking bench for the detector
// Drives a short table of hand-picked samples and clear commands, then
// random sample streams under several register settings and stall patterns.
// Every result word is checked against the table or an in-bench window predictor.
// ----------------------------------------------------------------------------
module tilt_gesture_window_detector_top_test;

  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 400;
  localparam int SEGMENTS     = 6;

  // Short names for the table rows
  localparam logic       SMP  = tgwd_pkg::OP_SAMPLE;
  localparam logic       CLR  = tgwd_pkg::OP_CLEAR;
  localparam logic [1:0] NONE = tgwd_pkg::GEST_NONE;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  tgwd_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tgwd_pkg::out_word_t out_word;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [15:0]         cfg_data;

  tilt_gesture_window_detector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: registers, last taken sample and the z ring
  logic [15:0]        z_limit = tgwd_pkg::Z_CHANGE_LIMIT_RST;
  logic [15:0]        margin  = tgwd_pkg::SAME_SAMPLE_MARGIN_RST;
  logic signed [15:0] last_x  = '0;
  logic signed [15:0] last_y  = '0;
  logic signed [15:0] last_z  = '0;
  logic signed [15:0] z_ring [tgwd_pkg::WINDOW_DEPTH];
  int                 ring_slot = 0;
  int                 ring_fill = 0;

  tgwd_pkg::out_word_t gesture_queue [$];
  int        mismatches    = 0;
  int        quiet_cycles  = 0;
  int        send_idle_pct = 6;
  int        recv_idle_pct = 81;

  typedef struct packed {
    logic               op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               typed_in;
    logic [1:0]         code;
    logic               taken;
  } dir_row_t;

  // Reset state: limit 2000, margin 100, last sample (0,0,0)
  dir_row_t dir_rows [21] = '{
    '{SMP,      0,      0,      0, 1'b1, NONE, 1'b0}, // same as reset sample
    '{SMP,     99,    -99,     99, 1'b1, NONE, 1'b0}, // all axes inside margin
    '{SMP,      0,      0,    100, 1'b1, NONE, 1'b1}, // z alone at margin
    '{SMP,      0,    100,    100, 1'b1, NONE, 1'b1}, // y alone at margin
    '{SMP,    100,    100,    100, 1'b1, NONE, 1'b1}, // x alone at margin
    '{CLR, -32768,  32767,     -1, 1'b1, NONE, 1'b0},
    '{SMP,    100,    100,    100, 1'b1, NONE, 1'b0}, // clear keeps last sample
    '{SMP,  32767,  32767,  32767, 1'b1, NONE, 1'b1},
    '{SMP, -32768, -32768, -32768, 1'b1, NONE, 1'b1},
    '{SMP,      0,      0,      0, 1'b0, NONE, 1'b0},
    '{SMP,   1000,   1000,   1000, 1'b0, NONE, 1'b0},
    '{SMP,  -1000,  -1000,  -1000, 1'b0, NONE, 1'b0},
    '{SMP,   2000,   2000,   2000, 1'b0, NONE, 1'b0},
    '{SMP,      0,      0,   2001, 1'b0, NONE, 1'b0},
    '{SMP,      0,      0, -32768, 1'b0, NONE, 1'b0}, // window full: fall
    '{SMP,      0,      0,  32767, 1'b0, NONE, 1'b0}, // rise
    '{SMP,     50,    -50,  32700, 1'b1, NONE, 1'b0}, // duplicate when full
    '{SMP,      0,      0,  -1999, 1'b0, NONE, 1'b0},
    '{SMP,      0,      0,     -1, 1'b0, NONE, 1'b0},
    '{CLR,      0,      0,      0, 1'b1, NONE, 1'b0},
    '{SMP,   5000,      0,      0, 1'b1, NONE, 1'b1}  // window refilling
  };

  function automatic bit within_margin(logic signed [15:0] a, logic signed [15:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    return d < int'(margin);
  endfunction

  // Advance the predictor by one word and return the result it causes
  function automatic tgwd_pkg::out_word_t detect_gesture(tgwd_pkg::in_word_t w);
    tgwd_pkg::out_word_t r;
    int                  newest;
    int                  oldest;
    r.gesture_code = tgwd_pkg::GEST_NONE;
    r.sample_taken = 1'b0;
    if (w.operation == tgwd_pkg::OP_CLEAR) begin
      ring_slot = 0;
      ring_fill = 0;
      return r;
    end
    if (within_margin(w.accel_x, last_x) && within_margin(w.accel_y, last_y) &&
        within_margin(w.accel_z, last_z))
      return r;
    last_x = w.accel_x;
    last_y = w.accel_y;
    last_z = w.accel_z;
    z_ring[ring_slot] = w.accel_z;
    ring_slot = (ring_slot + 1) % tgwd_pkg::WINDOW_DEPTH;
    if (ring_fill < tgwd_pkg::WINDOW_DEPTH) ring_fill++;
    r.sample_taken = 1'b1;
    if (ring_fill == tgwd_pkg::WINDOW_DEPTH) begin
      newest = w.accel_z;
      oldest = z_ring[ring_slot];
      if (oldest - newest > int'(z_limit))
        r.gesture_code = tgwd_pkg::GEST_FALL;
      else if (newest - oldest > int'(z_limit))
        r.gesture_code = tgwd_pkg::GEST_RISE;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] nudge(logic signed [15:0] base, int span);
    int v;
    v = int'(base) + int'($urandom_range(2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Mostly samples near the last one, so duplicates and gestures both occur
  function automatic tgwd_pkg::in_word_t random_word();
    tgwd_pkg::in_word_t w;
    int                 pick;
    int                 zspan;
    pick = $urandom_range(99);
    w.operation = tgwd_pkg::OP_SAMPLE;
    w.accel_x   = 16'($urandom);
    w.accel_y   = 16'($urandom);
    w.accel_z   = 16'($urandom);
    zspan = int'(z_limit) + 2000;
    if (pick < 4) begin
      w.operation = tgwd_pkg::OP_CLEAR;
    end else if (pick < 25) begin
      w.accel_x = nudge(last_x, int'(margin));
      w.accel_y = nudge(last_y, int'(margin));
      w.accel_z = nudge(last_z, int'(margin));
    end else if (pick < 85) begin
      w.accel_x = nudge(last_x, 400);
      w.accel_y = nudge(last_y, 400);
      w.accel_z = nudge(last_z, zspan);
    end
    return w;
  endfunction

  task automatic send_word(tgwd_pkg::in_word_t w, bit typed_in,
                           tgwd_pkg::out_word_t typed);
    tgwd_pkg::out_word_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    // hold the word until it is taken
    do @(posedge clk); while (in_stall);
    pred = detect_gesture(w);
    gesture_queue.push_back(typed_in ? typed : pred);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == tgwd_pkg::CFG_Z_CHANGE_LIMIT) z_limit = data;
    else margin = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (gesture_queue.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    tgwd_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (gesture_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: code %0d taken %0d",
                   out_word.gesture_code, out_word.sample_taken);
      end else begin
        want = gesture_queue.pop_front();
        if (out_word.gesture_code !== want.gesture_code ||
            out_word.sample_taken !== want.sample_taken) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected code %0d taken %0d, got code %0d taken %0d",
                     want.gesture_code, want.sample_taken,
                     out_word.gesture_code, out_word.sample_taken);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    tgwd_pkg::in_word_t w;
    logic [15:0]        lim;
    logic [15:0]        mar;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= tgwd_pkg::CFG_Z_CHANGE_LIMIT;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      w.operation = dir_rows[i].op;
      w.accel_x   = dir_rows[i].x;
      w.accel_y   = dir_rows[i].y;
      w.accel_z   = dir_rows[i].z;
      send_word(w, dir_rows[i].typed_in,
                tgwd_pkg::out_word_t'{dir_rows[i].code, dir_rows[i].taken});
    end
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      send_idle_pct = (seg < 2) ? 6 : (seg < 4) ? 81 : 0;
      recv_idle_pct = (seg < 2) ? 81 : (seg < 4) ? 6 : 0;
      case (seg)
        0: begin
          lim = 16'd0;
          mar = 16'd0;
        end
        1: begin
          lim = 16'hFFFF;
          mar = 16'hFFFF;
        end
        2: begin
          lim = 16'd1500;
          mar = 16'd300;
        end
        3: begin
          lim = 16'($urandom_range(4000));
          mar = 16'($urandom_range(500));
        end
        4: begin
          lim = tgwd_pkg::Z_CHANGE_LIMIT_RST;
          mar = tgwd_pkg::SAME_SAMPLE_MARGIN_RST;
        end
        default: begin
          lim = 16'($urandom_range(65535));
          mar = 16'($urandom_range(2000));
        end
      endcase
      write_reg(tgwd_pkg::CFG_Z_CHANGE_LIMIT, lim);
      write_reg(tgwd_pkg::CFG_SAME_SAMPLE_MARGIN, mar);
      repeat (RANDOM_ITEMS / SEGMENTS) send_word(random_word(), 1'b0, '0);
      drain();
    end

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tgwd_pkg.sv
rtl/tgwd_cell.sv
rtl/tgwd_out_buf.sv
rtl/tilt_gesture_window_detector_top.sv
bench/tilt_gesture_window_detector_top_test.sv
